@@ rtl/core/centered_binomial_sampler_defines.svh @@
`ifndef CENTERED_BINOMIAL_SAMPLER_DEFINES_SVH
`define CENTERED_BINOMIAL_SAMPLER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define CBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define CBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked through reset.
`define CBS_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cbs_pkg.sv @@
package cbs_pkg;

    localparam int unsigned POLY_LENGTH = 256;
    localparam int unsigned POS_W       = $clog2(POLY_LENGTH);

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ETA_W      = 2;
    localparam int unsigned COEFF_W    = 3;
    localparam int unsigned NUM_COEFFS = 8;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned INDEX_W    = 8;

    localparam int unsigned SUM_W = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

    localparam int unsigned M_PAYLOAD_W = NUM_COEFFS * COEFF_W + COUNT_W + INDEX_W;
    localparam int unsigned M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;

    localparam logic [ETA_W-1:0] ETA_2 = 2'd2;
    localparam logic [ETA_W-1:0] ETA_3 = 2'd3;

    localparam logic [WORD_W-1:0] PAIR_MASK   = 32'h5555_5555;
    localparam logic [WORD_W-1:0] TRIPLE_MASK = 32'h0024_9249;
    localparam logic [WORD_W-1:0] LOW24_MASK  = 32'h00FF_FFFF;

    localparam logic [COUNT_W-1:0] COUNT_ETA2 = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_ETA3 = 4'd4;

    typedef struct packed {
        logic [COUNT_W-1:0]                   count;
        logic [NUM_COEFFS-1:0][COEFF_W-1:0]  coeff;
    } coeff_set_t;

endpackage

@@ rtl/core/cbs_sampler.sv @@
module cbs_sampler (
    input  logic [cbs_pkg::WORD_W-1:0] word,
    input  logic [cbs_pkg::ETA_W-1:0]  eta,
    output cbs_pkg::coeff_set_t        result
);

    logic [cbs_pkg::WORD_W-1:0] t3;
    logic [cbs_pkg::WORD_W-1:0] d2;
    logic [cbs_pkg::WORD_W-1:0] d3;

    always_comb begin
        logic [cbs_pkg::COEFF_W-1:0] a;
        logic [cbs_pkg::COEFF_W-1:0] b;
        t3 = word & cbs_pkg::LOW24_MASK;
        d2 = (word & cbs_pkg::PAIR_MASK) + ((word >> 1) & cbs_pkg::PAIR_MASK);
        d3 = (t3 & cbs_pkg::TRIPLE_MASK) + ((t3 >> 1) & cbs_pkg::TRIPLE_MASK)
           + ((t3 >> 2) & cbs_pkg::TRIPLE_MASK);
        result = '0;
        a = '0;
        b = '0;
        if (eta == cbs_pkg::ETA_3) begin
            for (int j = 0; j < 4; j++) begin
                a = d3[6*j +: 3];
                b = d3[6*j+3 +: 3];
                result.coeff[j] = a - b;
            end
            result.count = cbs_pkg::COUNT_ETA3;
        end else begin
            for (int j = 0; j < 8; j++) begin
                a = {1'b0, d2[4*j +: 2]};
                b = {1'b0, d2[4*j+1 +: 2]};
                result.coeff[j] = a - b;
            end
            result.count = cbs_pkg::COUNT_ETA2;
        end
    end

endmodule

@@ rtl/core/centered_binomial_sampler.sv @@
// Centered binomial sampler: each 32-bit random word taken on the slave side
// yields one request on the master side with eight coefficients (eta not 3)
// or four (eta 3, low 24 bits only, upper coefficients zero), the polynomial
// index of the first one, and tlast on the request completing a polynomial.
// One word is taken every cycle unless the master side stalls; each word goes
// through the input register, then the result register, with the sampling
// logic and the position counter update between. Write eta only while idle.
module centered_binomial_sampler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cbs_pkg::ETA_W-1:0]       cfg_wr_data,   // eta
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cbs_pkg::WORD_W-1:0]      s_tdata,       // random_word
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // coeff_0..coeff_7 (3 bits each), coeff_count, first_index, zero pad
    output logic [cbs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast        // poly_done
);

    logic [cbs_pkg::ETA_W-1:0]   eta_reg;
    logic                        in_valid_reg;
    logic [cbs_pkg::WORD_W-1:0]  in_word_reg;
    logic                        out_valid_reg;
    cbs_pkg::coeff_set_t         set_reg;
    logic [cbs_pkg::INDEX_W-1:0] index_reg;
    logic                        last_reg;
    logic [cbs_pkg::POS_W-1:0]   pos_reg;
    logic [cbs_pkg::POS_W-1:0]   pos_next;
    logic [cbs_pkg::SUM_W-1:0]   pos_sum;
    logic                        wrap;
    logic                        advance;
    cbs_pkg::coeff_set_t         set_next;

    cbs_sampler u_sampler (
        .word   (in_word_reg),
        .eta    (eta_reg),
        .result (set_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign pos_sum  = cbs_pkg::SUM_W'(pos_reg) + cbs_pkg::SUM_W'(set_next.count);
    assign wrap     = pos_sum >= cbs_pkg::SUM_W'(cbs_pkg::POLY_LENGTH);
    assign pos_next = wrap ? '0 : cbs_pkg::POS_W'(pos_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eta_reg       <= cbs_pkg::ETA_2;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                eta_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_word_reg <= s_tdata;
        end
        if (advance) begin
            set_reg   <= set_next;
            index_reg <= cbs_pkg::INDEX_W'(pos_reg);
            last_reg  <= wrap;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cbs_pkg::M_TDATA_W'({index_reg, set_reg});
    assign m_tlast  = last_reg;

endmodule

@@ rtl/core/cbs_checker.sv @@
`include "centered_binomial_sampler_defines.svh"

module cbs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cbs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    localparam int unsigned COUNT_LO = cbs_pkg::NUM_COEFFS * cbs_pkg::COEFF_W;
    localparam int unsigned HALF_W   = COUNT_LO / 2;

    logic [cbs_pkg::COUNT_W-1:0] count;
    logic [HALF_W-1:0]           upper_coeffs;

    assign count        = m_tdata[COUNT_LO +: cbs_pkg::COUNT_W];
    assign upper_coeffs = m_tdata[HALF_W +: HALF_W];

    `CBS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled request changed")

    `CBS_ASSERT_NOW(a_count_legal, m_tvalid,
        count == cbs_pkg::COUNT_ETA2 || count == cbs_pkg::COUNT_ETA3,
        "coefficient count is neither 8 nor 4")

    `CBS_ASSERT_NOW(a_upper_zero, m_tvalid && count == cbs_pkg::COUNT_ETA3,
        upper_coeffs == '0, "upper coefficients nonzero with four-coefficient request")

    `CBS_ASSERT_RST(a_reset_idle, $past(!aresetn), !m_tvalid,
        "request valid right after reset")

endmodule

bind centered_binomial_sampler cbs_checker u_cbs_checker (.*);

@@ tb/centered_binomial_checker.sv @@
module centered_binomial_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cbs_pkg::ETA_W-1:0]         cfg_wr_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [cbs_pkg::WORD_W-1:0]        s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [cbs_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              m_tlast,
    output int unsigned                       error_count,
    output int unsigned                       pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] PAIR_BITS   = 32'h5555_5555;
    localparam logic [31:0] TRIPLE_BITS = 32'h0024_9249;
    localparam logic [31:0] LOW24_BITS  = 32'h00FF_FFFF;
    localparam logic [3:0]  PAIR_COUNT   = 4'd8;
    localparam logic [3:0]  TRIPLE_COUNT = 4'd4;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0][2:0] coeff;
        logic [3:0]      count;
        logic [7:0]      first_index;
        logic            done;
    } coeff_set_t;

    coeff_set_t  coeff_sets_due[$];
    logic [1:0]  eta_reg;
    int unsigned coeff_pos;

    function automatic coeff_set_t sample_coeffs(input logic [31:0] word,
                                                 input logic [1:0] eta_sel,
                                                 input logic [7:0] index);
        coeff_set_t r;
        logic [31:0] t;
        logic [31:0] d;
        logic [2:0] a;
        logic [2:0] b;
        r = '0;
        if (eta_sel == cbs_pkg::ETA_3) begin
            t = word & LOW24_BITS;
            d = (t & TRIPLE_BITS) + ((t >> 1) & TRIPLE_BITS) + ((t >> 2) & TRIPLE_BITS);
            for (int j = 0; j < 4; j++) begin
                a = d[6*j +: 3];
                b = d[6*j+3 +: 3];
                r.coeff[j] = a - b;
            end
            r.count = TRIPLE_COUNT;
        end else begin
            d = (word & PAIR_BITS) + ((word >> 1) & PAIR_BITS);
            for (int j = 0; j < 8; j++) begin
                a = {1'b0, d[4*j +: 2]};
                b = {1'b0, d[4*j+1 +: 2]};
                r.coeff[j] = a - b;
            end
            r.count = PAIR_COUNT;
        end
        r.first_index = index;
        return r;
    endfunction

    always @(posedge aclk) begin
        coeff_set_t want;
        coeff_set_t got;
        int unsigned next_pos;
        if (!aresetn) begin
            eta_reg = cbs_pkg::ETA_2;
            coeff_pos = 0;
            coeff_sets_due.delete();
            error_count = 0;
        end else begin
            if (cfg_wr_en)
                eta_reg = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                want = sample_coeffs(s_tdata, eta_reg, coeff_pos[7:0]);
                next_pos = coeff_pos + want.count;
                if (next_pos >= cbs_pkg::POLY_LENGTH) begin
                    want.done = 1'b1;
                    coeff_pos = 0;
                end else begin
                    coeff_pos = next_pos;
                end
                coeff_sets_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                for (int j = 0; j < 8; j++)
                    got.coeff[j] = m_tdata[3*j +: 3];
                got.count       = m_tdata[24 +: 4];
                got.first_index = m_tdata[28 +: 8];
                got.done        = m_tlast;
                if (coeff_sets_due.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result request: coeff=%h count=%0d index=%0d last=%b",
                                 $realtime, got.coeff, got.count, got.first_index, got.done);
                end else begin
                    want = coeff_sets_due.pop_front();
                    if (got.coeff !== want.coeff || got.count !== want.count ||
                        got.first_index !== want.first_index || got.done !== want.done) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: mismatch: coeff exp %h act %h, count exp %0d act %0d, index exp %0d act %0d, last exp %b act %b",
                                     $realtime, want.coeff, got.coeff, want.count, got.count,
                                     want.first_index, got.first_index, want.done, got.done);
                    end
                end
            end
        end
        pending_count = coeff_sets_due.size();
    end

endmodule

@@ tb/tb_centered_binomial_sampler.sv @@
module tb_centered_binomial_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  ETA_SPARE_0 = 2'd0;
    localparam logic [1:0]  ETA_SPARE_1 = 2'd1;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [cbs_pkg::ETA_W-1:0]       cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [cbs_pkg::WORD_W-1:0]      s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [cbs_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;

    int unsigned error_count;
    int unsigned pending_count;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;

    always #2 aclk = ~aclk;

    centered_binomial_sampler dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    centered_binomial_checker checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always @(negedge aclk)
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 9);

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic [31:0] word);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    task automatic write_eta(input logic [1:0] eta_val);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= eta_val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_words(input logic [1:0] eta_val, input int unsigned n_words);
        logic [31:0] word;
        write_eta(eta_val);
        for (int unsigned k = 0; k < n_words; k++) begin
            case ($urandom_range(9))
                0:       word = '0;
                1:       word = '1;
                2:       word = $urandom & $urandom & $urandom;
                3:       word = $urandom | $urandom | $urandom;
                default: word = $urandom;
            endcase
            send_word(word);
        end
    endtask

    initial begin
        logic [31:0] pair_words[10];
        logic [31:0] triple_words[9];
        pair_words   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                         32'h3333_3333, 32'hCCCC_CCCC, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                         32'h1234_5678, 32'h8000_0001};
        triple_words = '{32'h0000_0000, 32'h00FF_FFFF, 32'hFF00_0000, 32'hFFFF_FFFF,
                         32'h0024_9249, 32'h0049_2492, 32'h0092_4924, 32'hA5DB_6DB6,
                         32'h0000_0007};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        write_eta(cbs_pkg::ETA_2);
        foreach (pair_words[i])
            send_word(pair_words[i]);
        write_eta(cbs_pkg::ETA_3);
        foreach (triple_words[i])
            send_word(triple_words[i]);
        write_eta(ETA_SPARE_0);
        send_word(32'hFFFF_FFFF);
        send_word(32'h5555_5555);
        write_eta(ETA_SPARE_1);
        send_word(32'hAAAA_AAAA);
        send_word(32'h0000_0000);

        random_words(cbs_pkg::ETA_3, 140);
        random_words(cbs_pkg::ETA_2, 130);
        random_words(ETA_SPARE_0, 90);
        random_words(cbs_pkg::ETA_3, 147);
        steady = 1'b1;
        random_words(cbs_pkg::ETA_2, 160);
        steady = 1'b0;
        random_words(ETA_SPARE_1, 90);
        random_words(cbs_pkg::ETA_3, 123);
        random_words(cbs_pkg::ETA_2, 121);
        random_words(cbs_pkg::ETA_3, 101);
        drain();

        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
